// File: hw/rtl/plss_pkg.sv
`default_nettype none

package plss_pkg;

  localparam int SAMPLE_WIDTH_DEF = 12;
  localparam int CFG_INDEX_WIDTH = 3;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_LOW_THRESHOLD  = 3'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_HIGH_THRESHOLD = 3'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_RESTORE_COUNT  = 3'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_LOSS_COUNT     = 3'd3;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_CUT_COUNT      = 3'd4;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_WAIT_LIMIT     = 3'd5;

  localparam logic [11:0] LOW_THRESHOLD_RST  = 12'd50;
  localparam logic [11:0] HIGH_THRESHOLD_RST = 12'd250;
  localparam logic [7:0]  RESTORE_COUNT_RST  = 8'd4;
  localparam logic [7:0]  LOSS_COUNT_RST     = 8'd30;
  localparam logic [7:0]  CUT_COUNT_RST      = 8'd65;
  localparam logic [7:0]  WAIT_LIMIT_RST     = 8'd60;

  localparam logic [7:0] COUNT_MAX = 8'hFF;

  localparam logic [1:0] ERR_NONE     = 2'b00;
  localparam logic [1:0] ERR_WAITING  = 2'b01;
  localparam logic [1:0] ERR_HOST_OFF = 2'b10;

  // Count limits held by the register file.
  typedef struct packed {
    logic [7:0] restore_count;
    logic [7:0] loss_count;
    logic [7:0] cut_count;
    logic [7:0] wait_limit;
  } limits_t;

  // One result item.
  typedef struct packed {
    logic restart_pulse;
    logic shutdown_pulse;
    logic power_cut;
    logic err_waiting;
    logic err_host_off;
  } result_t;

endpackage

`default_nettype wire

// File: hw/rtl/plss_cfg.sv
`default_nettype none

module plss_cfg #(
  parameter int SAMPLE_WIDTH = plss_pkg::SAMPLE_WIDTH_DEF
) (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  cfg_write,
  input  wire  [plss_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  wire  [SAMPLE_WIDTH-1:0]              cfg_data,
  output logic [SAMPLE_WIDTH-1:0]              low_threshold,
  output logic [SAMPLE_WIDTH-1:0]              high_threshold,
  output plss_pkg::limits_t                    limits
);
  import plss_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      low_threshold        <= SAMPLE_WIDTH'(LOW_THRESHOLD_RST);
      high_threshold       <= SAMPLE_WIDTH'(HIGH_THRESHOLD_RST);
      limits.restore_count <= RESTORE_COUNT_RST;
      limits.loss_count    <= LOSS_COUNT_RST;
      limits.cut_count     <= CUT_COUNT_RST;
      limits.wait_limit    <= WAIT_LIMIT_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_LOW_THRESHOLD:  low_threshold        <= cfg_data;
        REG_HIGH_THRESHOLD: high_threshold       <= cfg_data;
        REG_RESTORE_COUNT:  limits.restore_count <= cfg_data[7:0];
        REG_LOSS_COUNT:     limits.loss_count    <= cfg_data[7:0];
        REG_CUT_COUNT:      limits.cut_count     <= cfg_data[7:0];
        REG_WAIT_LIMIT:     limits.wait_limit    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/plss_core.sv
`default_nettype none

module plss_core #(
  parameter int SAMPLE_WIDTH = plss_pkg::SAMPLE_WIDTH_DEF
) (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     step,
  input  wire                     sample_valid,
  input  wire  [SAMPLE_WIDTH-1:0] supply_level,
  input  wire                     host_off,
  input  wire  [SAMPLE_WIDTH-1:0] low_threshold,
  input  wire  [SAMPLE_WIDTH-1:0] high_threshold,
  input  plss_pkg::limits_t       limits,
  output plss_pkg::result_t       result
);
  import plss_pkg::*;

  logic [7:0] loss_counter, loss_counter_next;
  logic [7:0] restore_counter, restore_counter_next;
  logic [7:0] wait_counter, wait_counter_next;
  logic       host_down_flag, host_down_flag_next;
  logic       cut_latch, cut_latch_next;
  logic [1:0] error_bits, error_bits_next;

  logic       is_low, is_high, restored, losing;
  logic [7:0] restore_inc, wait_inc, loss_mid;
  logic       host_down_mid;
  logic [1:0] error_mid;
  logic       restart, shutdown;

  always_comb begin
    // Supply sample: a sample that is both low and high counts as low.
    is_low      = sample_valid && (supply_level < low_threshold);
    is_high     = sample_valid && !is_low && (supply_level > high_threshold);
    restore_inc = restore_counter + 8'd1;
    restored    = is_high && (restore_inc >= limits.restore_count);
    restart     = restored && host_down_flag && host_off;

    loss_mid = loss_counter;
    if (restored) begin
      loss_mid = 8'd0;
    end else if (is_low && loss_counter != COUNT_MAX) begin
      loss_mid = loss_counter + 8'd1;
    end

    restore_counter_next = restore_counter;
    if (is_high) begin
      restore_counter_next = restored ? 8'd0 : restore_inc;
    end

    error_mid     = restored ? ERR_NONE : error_bits;
    host_down_mid = host_down_flag && !restart;

    // Loss handling sees the counters after the sample update.
    losing              = loss_mid >= limits.loss_count;
    wait_inc            = wait_counter + 8'd1;
    loss_counter_next   = loss_mid;
    wait_counter_next   = wait_counter;
    host_down_flag_next = host_down_mid;
    error_bits_next     = error_mid;
    shutdown            = 1'b0;
    cut_latch_next      = cut_latch ||
                          (losing && host_down_mid && loss_mid >= limits.cut_count);
    if (losing) begin
      if (host_off) begin
        host_down_flag_next = 1'b1;
        shutdown            = 1'b1;
        error_bits_next     = ERR_HOST_OFF;
      end else if (wait_inc < limits.wait_limit) begin
        wait_counter_next = wait_inc;
        error_bits_next   = ERR_WAITING;
      end else begin
        wait_counter_next = 8'd0;
        shutdown          = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      loss_counter    <= 8'd0;
      restore_counter <= 8'd0;
      wait_counter    <= 8'd0;
      host_down_flag  <= 1'b0;
      cut_latch       <= 1'b0;
      error_bits      <= ERR_NONE;
    end else if (step) begin
      loss_counter    <= loss_counter_next;
      restore_counter <= restore_counter_next;
      wait_counter    <= wait_counter_next;
      host_down_flag  <= host_down_flag_next;
      cut_latch       <= cut_latch_next;
      error_bits      <= error_bits_next;
    end
  end

  always_comb begin
    result.restart_pulse  = restart;
    result.shutdown_pulse = shutdown;
    result.power_cut      = cut_latch_next;
    result.err_waiting    = error_bits_next[0];
    result.err_host_off   = error_bits_next[1];
  end

endmodule

`default_nettype wire

// File: hw/rtl/power_loss_shutdown_supervisor_unit.sv
// Power-loss shutdown supervisor.
// One input transaction on s_axis is one supervision tick: an optional supply
// sample and the host's powered-off status. Each tick yields exactly one
// result transaction on m_axis with the restart and shutdown pulses, the
// latched power-cut request and the two error flags.
// The six thresholds and limits are written through the cfg channel, which is
// always ready; write them only while no tick is in flight.
// A tick is first held in an input register; the supervisor state and the
// result register are then updated together from it, once the result register
// is free. Throughput is one tick per cycle while the receiver does not stall.
// When the receiver stalls, the result register holds its item and the input
// register takes one more tick; s_axis_tready then drops until the result is
// taken. Reset clears the supervisor state, restores the register defaults
// and empties both registers.
`default_nettype none

module power_loss_shutdown_supervisor_unit #(
  parameter int SAMPLE_WIDTH = plss_pkg::SAMPLE_WIDTH_DEF,
  localparam int InWidth = ((SAMPLE_WIDTH + 2 + 7) / 8) * 8
) (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  s_axis_tvalid,
  output logic                                 s_axis_tready,
  // sample_valid, supply_level, host_off, zero fill
  input  wire  [InWidth-1:0]                   s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  wire                                  m_axis_tready,
  // restart_pulse, shutdown_pulse, power_cut, err_waiting, err_host_off, zero fill
  output logic [7:0]                           m_axis_tdata,
  input  wire                                  cfg_valid,
  output logic                                 cfg_ready,
  input  wire  [plss_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  wire  [SAMPLE_WIDTH-1:0]              cfg_data
);
  import plss_pkg::*;

  logic                    in_valid;
  logic                    in_sample_valid;
  logic [SAMPLE_WIDTH-1:0] in_supply_level;
  logic                    in_host_off;
  logic                    advance;
  logic                    out_valid;
  result_t                 out_result;
  result_t                 core_result;
  logic [SAMPLE_WIDTH-1:0] low_threshold;
  logic [SAMPLE_WIDTH-1:0] high_threshold;
  limits_t                 limits;

  assign cfg_ready     = 1'b1;
  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  plss_cfg #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_cfg (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_valid && cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .low_threshold  (low_threshold),
    .high_threshold (high_threshold),
    .limits         (limits)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_sample_valid <= s_axis_tdata[0];
      in_supply_level <= s_axis_tdata[SAMPLE_WIDTH:1];
      in_host_off     <= s_axis_tdata[SAMPLE_WIDTH+1];
    end
  end

  plss_core #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_core (
    .clk            (clk),
    .rst            (rst),
    .step           (advance),
    .sample_valid   (in_sample_valid),
    .supply_level   (in_supply_level),
    .host_off       (in_host_off),
    .low_threshold  (low_threshold),
    .high_threshold (high_threshold),
    .limits         (limits),
    .result         (core_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result <= core_result;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {3'b000, out_result.err_host_off, out_result.err_waiting,
                          out_result.power_cut, out_result.shutdown_pulse,
                          out_result.restart_pulse};

endmodule

`default_nettype wire

// File: hw/rtl/plss_checker.sv
`default_nettype none

module plss_checker #(
  parameter int SAMPLE_WIDTH = plss_pkg::SAMPLE_WIDTH_DEF,
  localparam int InWidth = ((SAMPLE_WIDTH + 2 + 7) / 8) * 8
) (
  input wire                clk,
  input wire                rst,
  input wire                s_axis_tvalid,
  input wire                s_axis_tready,
  input wire  [InWidth-1:0] s_axis_tdata,
  input wire                m_axis_tvalid,
  input wire                m_axis_tready,
  input wire  [7:0]         m_axis_tdata
);

  // Reset leaves no result pending and the input side open.
  assert property (@(posedge clk) rst |=> !m_axis_tvalid && s_axis_tready)
    else $error("block not empty after reset");

  // The input side only closes while a result is stalled at the output.
  assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without an output stall");

  // A stalled result holds its value.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // Once a power cut has been reported, every later result reports it too.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[2] |=> !m_axis_tvalid || m_axis_tdata[2])
    else $error("power cut latch dropped");

  // An accepted tick carries known data and is followed by a result on offer at the output.
  assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |-> !$isunknown(s_axis_tdata) ##2 m_axis_tvalid)
    else $error("accepted tick produced no result");

endmodule

bind power_loss_shutdown_supervisor_unit plss_checker #(
  .SAMPLE_WIDTH(SAMPLE_WIDTH)
) u_plss_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// File: dv/power_loss_shutdown_supervisor_unit_tb.sv
`timescale 1ns / 100ps

module power_loss_shutdown_supervisor_unit_tb;
  import plss_pkg::*;

  // Index with no register behind it; a write there must change nothing.
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_UNUSED = 3'd7;

  typedef enum int {
    RUN_OUTAGE,
    RUN_NOISE
  } run_kind_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // sample_valid, supply_level, host_off, zero fill
  logic [15:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b1;
  // restart_pulse, shutdown_pulse, power_cut, err_waiting, err_host_off, zero fill
  logic [7:0]  m_axis_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
  logic [11:0] cfg_data = '0;

  power_loss_shutdown_supervisor_unit DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // Predicted supervisor: thresholds, limits and state.
  logic [11:0] low_thr;
  logic [11:0] high_thr;
  limits_t     lim;
  logic [7:0]  loss_cnt;
  logic [7:0]  restore_cnt;
  logic [7:0]  wait_cnt;
  logic        host_down;
  logic        cut_latched;
  logic [1:0]  err_bits;

  result_t expected_results[$];
  int      errors = 0;
  int      tick_count = 0;
  int      settings_count = 0;
  int      restarts_seen = 0;
  int      shutdowns_seen = 0;
  int      cut_ticks = 0;
  bit      steady_run = 1'b0;

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic supervise_tick(input logic sv, input logic [11:0] lvl, input logic off);
    result_t r;
    r = '0;
    if (sv) begin
      if (lvl < low_thr) begin
        if (loss_cnt != COUNT_MAX) loss_cnt = loss_cnt + 8'd1;
      end else if (lvl > high_thr) begin
        restore_cnt = restore_cnt + 8'd1;
        if (restore_cnt >= lim.restore_count) begin
          restore_cnt = '0;
          loss_cnt    = '0;
          err_bits    = ERR_NONE;
          if (host_down && off) begin
            r.restart_pulse = 1'b1;
            host_down       = 1'b0;
          end
        end
      end
    end
    if (loss_cnt >= lim.loss_count) begin
      if (host_down && loss_cnt >= lim.cut_count) cut_latched = 1'b1;
      if (off) begin
        host_down        = 1'b1;
        r.shutdown_pulse = 1'b1;
        err_bits         = ERR_HOST_OFF;
      end else begin
        wait_cnt = wait_cnt + 8'd1;
        if (wait_cnt < lim.wait_limit) begin
          err_bits = ERR_WAITING;
        end else begin
          wait_cnt         = '0;
          r.shutdown_pulse = 1'b1;
        end
      end
    end
    r.power_cut    = cut_latched;
    r.err_waiting  = err_bits[0];
    r.err_host_off = err_bits[1];
    expected_results.push_back(r);
    tick_count++;
    restarts_seen  += r.restart_pulse;
    shutdowns_seen += r.shutdown_pulse;
    cut_ticks      += r.power_cut;
  endtask

  task automatic send_tick(input logic sv, input logic [11:0] lvl, input logic off);
    if (!steady_run && $urandom_range(99) < 24) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 24);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, off, lvl, sv};
    do @(posedge clk); while (!s_axis_tready);
    supervise_tick(sv, lvl, off);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // The upper nibble of the 12-bit data word for each 8-bit limit carries random junk that must be ignored.
  task automatic apply_config(input logic [11:0] low, input logic [11:0] high,
                              input logic [7:0] rc, input logic [7:0] lc,
                              input logic [7:0] cc, input logic [7:0] wl);
    logic [CFG_INDEX_WIDTH-1:0] idx [7];
    logic [11:0]                val [7];
    idx = '{REG_LOW_THRESHOLD, REG_HIGH_THRESHOLD, REG_RESTORE_COUNT, REG_LOSS_COUNT,
            REG_CUT_COUNT, REG_WAIT_LIMIT, REG_UNUSED};
    val = '{low, high, {4'($urandom), rc}, {4'($urandom), lc}, {4'($urandom), cc},
            {4'($urandom), wl}, 12'($urandom)};
    wait_drained();
    for (int i = 0; i < 7; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      do @(posedge clk); while (!cfg_ready);
      case (idx[i])
        REG_LOW_THRESHOLD:  low_thr           = val[i];
        REG_HIGH_THRESHOLD: high_thr          = val[i];
        REG_RESTORE_COUNT:  lim.restore_count = val[i][7:0];
        REG_LOSS_COUNT:     lim.loss_count    = val[i][7:0];
        REG_CUT_COUNT:      lim.cut_count     = val[i][7:0];
        REG_WAIT_LIMIT:     lim.wait_limit    = val[i][7:0];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
    settings_count++;
  endtask

  function automatic logic [11:0] low_level();
    if (low_thr == 12'd0) return 12'($urandom);
    if ($urandom_range(7) == 0) return low_thr - 12'd1;
    return 12'($urandom_range(0, low_thr - 1));
  endfunction

  function automatic logic [11:0] high_level();
    if (high_thr == 12'hFFF) return 12'($urandom);
    if ($urandom_range(7) == 0) return high_thr + 12'd1;
    return 12'($urandom_range(high_thr + 1, 4095));
  endfunction

  // A supply outage: a run of mostly low samples while the host may go off,
  // followed by a run of mostly high samples that may restore and restart it.
  task automatic drive_outage();
    int   n_low;
    int   n_high;
    int   off_from;
    logic keep_off;
    n_low    = $urandom_range(0, int'(lim.cut_count) + 12);
    off_from = $urandom_range(0, n_low + 4);
    for (int i = 0; i < n_low; i++) begin
      if ($urandom_range(9) == 0) send_tick(1'b0, 12'($urandom), i >= off_from);
      else send_tick(1'b1, low_level(), i >= off_from);
    end
    n_high   = $urandom_range(0, int'(lim.restore_count) + 3);
    keep_off = ($urandom_range(4) != 0);
    for (int i = 0; i < n_high; i++) begin
      if ($urandom_range(9) == 0) send_tick(1'b0, 12'($urandom), keep_off);
      else send_tick(1'b1, high_level(), keep_off);
    end
  endtask

  task automatic run_random(input int n);
    int        start;
    int        burst;
    logic [11:0] lvl;
    run_kind_t kind;
    start = tick_count;
    while (tick_count - start < n) begin
      kind = ($urandom_range(3) != 0) ? RUN_OUTAGE : RUN_NOISE;
      if (kind == RUN_OUTAGE) begin
        drive_outage();
      end else begin
        burst = $urandom_range(1, 10);
        for (int i = 0; i < burst; i++) begin
          case ($urandom_range(4))
            0: lvl = low_thr;
            1: lvl = high_thr;
            2: lvl = 12'd0;
            3: lvl = 12'hFFF;
            default: lvl = 12'($urandom);
          endcase
          send_tick(1'($urandom), lvl, 1'($urandom));
        end
      end
    end
  endtask

  // Result checker and receiver back-pressure.
  always @(posedge clk) begin
    result_t    want;
    logic [4:0] want_bits;
    string      field_name [5];
    field_name = '{"restart_pulse", "shutdown_pulse", "power_cut", "err_waiting",
                   "err_host_off"};
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_results.size() == 0) begin
        $error("Result transaction 0x%02h arrived with no tick outstanding", m_axis_tdata);
        errors++;
      end else begin
        want      = expected_results.pop_front();
        want_bits = {want.err_host_off, want.err_waiting, want.power_cut,
                     want.shutdown_pulse, want.restart_pulse};
        for (int i = 0; i < 5; i++) begin
          if (m_axis_tdata[i] !== want_bits[i]) begin
            $error("%s: expected %0b, got %0b", field_name[i], want_bits[i], m_axis_tdata[i]);
            errors++;
          end
        end
      end
    end
    m_axis_tready <= (rst || steady_run) ? 1'b1 : ($urandom_range(99) >= 24);
  end

  task automatic test_field_extremes();
    send_tick(1'b0, 12'h000, 1'b0);
    send_tick(1'b1, 12'h000, 1'b0);
    send_tick(1'b1, 12'hFFF, 1'b1);
    send_tick(1'b1, 12'hAAA, 1'b0);
    send_tick(1'b1, 12'h555, 1'b1);
  endtask

  task automatic test_shutdown_sequence();
    apply_config(12'd50, 12'd250, 8'd2, 8'd2, 8'd3, 8'd2);
    send_tick(1'b1, 12'd300, 1'b0);
    send_tick(1'b1, 12'd300, 1'b0);
    send_tick(1'b1, 12'd10, 1'b0);
    send_tick(1'b0, 12'd0, 1'b0);
    send_tick(1'b1, 12'd10, 1'b0);
    send_tick(1'b1, 12'd10, 1'b0);
    send_tick(1'b1, 12'd10, 1'b1);
    send_tick(1'b1, 12'd10, 1'b1);
    send_tick(1'b1, 12'd300, 1'b1);
    send_tick(1'b1, 12'd300, 1'b1);
  endtask

  // With zero limits a restart and a shutdown can fall in the same tick.
  task automatic test_zero_limits();
    apply_config(12'd50, 12'd250, 8'd0, 8'd0, 8'd3, 8'd0);
    send_tick(1'b0, 12'd0, 1'b1);
    send_tick(1'b1, 12'hFFF, 1'b1);
    send_tick(1'b1, 12'd100, 1'b0);
    send_tick(1'b1, 12'hFFF, 1'b0);
  endtask

  // A sample below the low threshold and above the high one counts as low.
  task automatic test_inverted_thresholds();
    apply_config(12'd3000, 12'd100, 8'd4, 8'd30, 8'd65, 8'd60);
    send_tick(1'b1, 12'd2000, 1'b0);
    send_tick(1'b1, 12'd50, 1'b0);
    send_tick(1'b1, 12'd3500, 1'b0);
    send_tick(1'b1, 12'd3000, 1'b0);
  endtask

  task automatic test_random_small_limits();
    for (int p = 0; p < 3; p++) begin
      apply_config(12'($urandom), 12'($urandom), 8'($urandom_range(1, 10)),
                   8'($urandom_range(1, 10)), 8'($urandom_range(1, 20)),
                   8'($urandom_range(1, 10)));
      run_random(80);
    end
  endtask

  task automatic test_max_limits();
    apply_config(12'hFFF, 12'hFFE, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    run_random(250);
  endtask

  task automatic test_min_limits();
    apply_config(12'd1, 12'd0, 8'd1, 8'd1, 8'd1, 8'd1);
    run_random(160);
  endtask

  // Halfway through, the sender holds off until every result is back.
  task automatic test_random_limits_with_drain();
    apply_config(12'($urandom_range(1, 2000)), 12'($urandom_range(2000, 4094)),
                 8'($urandom_range(1, 255)), 8'($urandom_range(1, 60)),
                 8'($urandom_range(1, 90)), 8'($urandom_range(1, 80)));
    run_random(100);
    wait_drained();
    run_random(100);
  endtask

  task automatic test_defaults_back_to_back();
    apply_config(LOW_THRESHOLD_RST, HIGH_THRESHOLD_RST, RESTORE_COUNT_RST,
                 LOSS_COUNT_RST, CUT_COUNT_RST, WAIT_LIMIT_RST);
    steady_run = 1'b1;
    run_random(200);
  endtask

  initial begin
    low_thr     = LOW_THRESHOLD_RST;
    high_thr    = HIGH_THRESHOLD_RST;
    lim         = '{RESTORE_COUNT_RST, LOSS_COUNT_RST, CUT_COUNT_RST, WAIT_LIMIT_RST};
    loss_cnt    = '0;
    restore_cnt = '0;
    wait_cnt    = '0;
    host_down   = 1'b0;
    cut_latched = 1'b0;
    err_bits    = ERR_NONE;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_field_extremes();
    test_shutdown_sequence();
    test_zero_limits();
    test_inverted_thresholds();
    test_random_small_limits();
    test_max_limits();
    test_min_limits();
    test_random_limits_with_drain();
    test_defaults_back_to_back();

    wait_drained();
    repeat (10) @(posedge clk);
    $display("Supervised %0d ticks under %0d limit settings, with random gaps and stalls.",
             tick_count, settings_count);
    $display("Saw %0d restart and %0d shutdown pulses; power cut held on %0d ticks.",
             restarts_seen, shutdowns_seen, cut_ticks);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
